@@ rtl/shp3_pkg.sv @@
package shp3_pkg;

    localparam int MAX_WIDTH = 512;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int EFF_W     = $clog2(MAX_WIDTH + 1);
    localparam int LEAD_W    = $clog2(MAX_WIDTH + 2);
    localparam int WIDTH_W   = 10;
    localparam int HEIGHT_W  = 12;
    localparam int MIN_DIM   = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int N_TAPS    = 9;
    localparam int CENTER_TAP = 4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd480;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd360;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [7:0]          t_byte;
    typedef t_byte [2:0]         t_rgb;   // [2] red, [1] green, [0] blue
    typedef t_rgb [2:0][2:0]     t_win;   // [row][col], row 0 top, col 2 newest
    typedef logic [ADDR_W-1:0]   t_col;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       flush;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_pix_out;

    typedef struct packed {
        t_rgb upper;
        t_rgb lower;
    } t_ls_entry;

    // line store access and window shift request for one word
    typedef struct packed {
        logic valid;
        logic is_pix;
        t_col addr;
        t_rgb pix;
    } t_ls_req;

    typedef struct packed {
        logic emit;
        logic border;
        logic frame_end;
    } t_meta;

endpackage

@@ rtl/shp3_lane.sv @@
module shp3_lane import shp3_pkg::*; (
    input  t_byte [N_TAPS-1:0] i_taps,
    input  logic               i_border,
    output t_byte              o_value
);

    logic        [10:0] sum_nb;
    logic        [11:0] center9;
    logic signed [12:0] acc;

    always_comb begin
        sum_nb = '0;
        for (int k = 0; k < N_TAPS; k++) begin
            if (k != CENTER_TAP) begin
                sum_nb = sum_nb + 11'(i_taps[k]);
            end
        end
    end

    assign center9 = {1'b0, i_taps[CENTER_TAP], 3'b000} + 12'(i_taps[CENTER_TAP]);
    assign acc     = $signed({1'b0, center9}) - $signed({2'b00, sum_nb});

    always_comb begin
        if (i_border) begin
            o_value = i_taps[CENTER_TAP];
        end else if (acc >= 13'sd255) begin
            o_value = 8'hFF;
        end else if (acc <= 13'sd0) begin
            o_value = 8'h00;
        end else begin
            o_value = acc[7:0];
        end
    end

endmodule

@@ rtl/shp3_window.sv @@
module shp3_window import shp3_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_ls_req i_req,
    output t_win    o_win
);

    t_ls_entry r_mem [MAX_WIDTH];
    t_ls_entry r_rd;
    t_ls_req   r_req;
    t_win      r_win;
    t_rgb      new_col [3];

    // read at accept, write back the shifted column once its request has moved into r_req
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= r_mem[i_req.addr];
            if (r_req.valid && r_req.is_pix) begin
                r_mem[r_req.addr] <= '{upper: r_rd.lower, lower: r_req.pix};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else if (i_en) begin
            r_req <= i_req;
        end
    end

    always_comb begin
        new_col[0] = r_rd.upper;
        new_col[1] = r_rd.lower;
        new_col[2] = r_req.is_pix ? r_req.pix : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_en && r_req.valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
                r_win[r][2] <= new_col[r];
            end
        end
    end

    assign o_win = r_win;

endmodule

@@ rtl/sharpen_3x3_rgb.sv @@
// 3x3 sharpen of an RGB raster stream: each interior pixel becomes nine times the
// center minus its eight neighbors, clamped to 0..255 per channel; first and last
// rows and columns pass through. Unless the output stalls, the block takes one word
// per clock and sends one result per clock once the window is primed. Results trail
// the input by W+1 words, so a frame's tail is pushed out by flush words given right
// after its last pixel (a flush at any other point is dropped). A word moves from
// acceptance to the output register by line store read, window shift with line store
// write-back, then the three channel lanes and the merge into the output register.
// The single line store (upper and lower row side by side, MAX_WIDTH entries) is read
// and written once per cycle, which sets the rate of one word per clock. Input is
// stalled only while a result waits in a stalled output register and the next result
// is ready behind it. Writing either register restarts the frame position.
module sharpen_3x3_rgb import shp3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_pix_in            i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_pix_out           o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    t_col                r_in_col,  n_in_col;
    logic [HEIGHT_W-1:0] r_in_row,  n_in_row;
    t_col                r_out_col, n_out_col;
    logic [HEIGHT_W-1:0] r_out_row, n_out_row;
    logic [LEAD_W-1:0]   r_lead,    n_lead;
    t_meta               r_s1, r_s2, n_s1;
    logic                r_out_valid;
    t_pix_out            r_out_word;

    logic [EFF_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    t_col                w_last;
    logic [HEIGHT_W-1:0] h_last;
    logic                en, accept, cfg_wr;
    logic                lead_full, flush_go, is_pix, emit;
    t_reg_idx            reg_idx;
    t_ls_req             req;
    t_win                win;
    t_byte [2:0][N_TAPS-1:0] lane_taps;
    t_byte [2:0]         lane_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1]);

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (int'(r_width) < MIN_DIM) begin
            w_eff = EFF_W'(MIN_DIM);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = EFF_W'(MAX_WIDTH);
        end else begin
            w_eff = EFF_W'(r_width);
        end
        h_eff = (int'(r_height) < MIN_DIM) ? HEIGHT_W'(MIN_DIM) : r_height;
    end

    assign w_last = ADDR_W'(w_eff - EFF_W'(1));
    assign h_last = h_eff - HEIGHT_W'(1);

    // the whole pipe moves unless the newest result would land on a held word
    assign en         = !(r_out_valid && i_out_stall && r_s2.emit);
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    assign lead_full = (r_lead == LEAD_W'(w_eff) + LEAD_W'(1));
    assign is_pix    = !i_in_word.flush;
    assign flush_go  = i_in_word.flush && (r_in_col == '0) && (r_in_row == '0)
                       && (r_lead != '0);
    assign emit      = flush_go || (is_pix && lead_full);

    always_comb begin
        req.valid  = accept && (is_pix || flush_go);
        req.is_pix = is_pix;
        req.pix    = {i_in_word.red_in, i_in_word.green_in, i_in_word.blue_in};
        if (is_pix) begin
            req.addr = r_in_col;
        end else begin
            req.addr = (r_out_col == w_last) ? '0 : r_out_col + t_col'(1);
        end

        n_s1.emit      = accept && emit;
        n_s1.border    = (r_out_col == '0) || (r_out_col == w_last) ||
                         (r_out_row == '0) || (r_out_row == h_last);
        n_s1.frame_end = (r_out_col == w_last) && (r_out_row == h_last);
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lead    = r_lead;
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lead    = '0;
        end else if (accept) begin
            if (is_pix) begin
                if (r_in_col == w_last) begin
                    n_in_col = '0;
                    n_in_row = (r_in_row == h_last) ? '0 : r_in_row + HEIGHT_W'(1);
                end else begin
                    n_in_col = r_in_col + t_col'(1);
                end
            end
            if (emit) begin
                if (r_out_col == w_last) begin
                    n_out_col = '0;
                    n_out_row = (r_out_row == h_last) ? '0 : r_out_row + HEIGHT_W'(1);
                end else begin
                    n_out_col = r_out_col + t_col'(1);
                end
            end
            if (is_pix && !emit) begin
                n_lead = r_lead + LEAD_W'(1);
            end else if (flush_go) begin
                n_lead = r_lead - LEAD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
        end else begin
            if (cfg_wr) begin
                case (reg_idx)
                    REG_IMAGE_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lead    <= n_lead;
        end
    end

    shp3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_req   (req),
        .o_win   (win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
        end
    end

    // one lane per channel, all reading the window after the word's shift
    for (genvar g = 0; g < 3; g++) begin : g_lane
        for (genvar r = 0; r < 3; r++) begin : g_row
            for (genvar c = 0; c < 3; c++) begin : g_col
                assign lane_taps[g][r*3+c] = win[r][c][g];
            end
        end
        shp3_lane u_lane (
            .i_taps   (lane_taps[g]),
            .i_border (r_s2.border),
            .o_value  (lane_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && r_s2.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // merge the lanes into the result word
    always_ff @(posedge i_clk) begin
        if (en && r_s2.emit) begin
            r_out_word.red_out   <= lane_val[2];
            r_out_word.green_out <= lane_val[1];
            r_out_word.blue_out  <= lane_val[0];
            r_out_word.frame_end <= r_s2.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/shp3_checker.sv @@
module shp3_checker import shp3_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_stall,
    input logic     i_out_valid,
    input logic     i_out_stall,
    input t_pix_out i_out_word,
    input logic     psel,
    input logic     penable,
    input logic     pready
);

    // a held result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> $stable(i_out_word))
        else $error("result word changed while stalled");

    // input back-pressure only comes from a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> (i_out_valid && i_out_stall))
        else $error("input stalled with output free");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("register access not ready");

endmodule

bind sharpen_3x3_rgb shp3_checker u_shp3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word),
    .psel        (psel),
    .penable     (penable),
    .pready      (pready)
);
